// File: rtl/lptsc_pkg.sv
// Shared types and constants for the length-prefix to start-code converter.
// Used by the front parser, the command queue, the back expander and the top level.
// No dependencies.
package lptsc_pkg;

   // Widths of the stream fields
   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 32;
   localparam int LEN_CNT_W    = 2;
   localparam int SC_BYTES     = 4;
   localparam int SC_IDX_W     = 2;

   // Default configuration; the queue holds a start code plus the payload
   // bytes that arrive while it is being expanded
   localparam int LENGTH_BYTES_DEF = 4;
   localparam int QUEUE_DEPTH_DEF  = 8;

   // Start code word, sent most significant byte first
   localparam logic [SC_BYTES*BYTE_W-1:0] START_CODE_WORD = 32'h0000_0001;

   // Command kinds passed from front to back
   typedef enum logic {
      CMD_PAYLOAD = 1'b0,
      CMD_START   = 1'b1
   } lptsc_kind_type;

   typedef struct packed {
      lptsc_kind_type     kind;
      logic [BYTE_W-1:0]  data;
   } lptsc_cmd_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } lptsc_qstat_type;

   // Byte of the start code at position idx (0 = first on the wire)
   function automatic logic [BYTE_W-1:0] start_code_byte(input logic [SC_IDX_W-1:0] idx);
      logic [SC_IDX_W-1:0] sel;
      sel = SC_IDX_W'(SC_BYTES - 1) - idx;
      return START_CODE_WORD[sel*BYTE_W +: BYTE_W];
   endfunction

endpackage

// File: rtl/lptsc_front.sv
// Front parser: accepts input beats, gathers the big-endian length and
// classifies each byte into queue commands. Depends on lptsc_pkg.
module lptsc_front #(
   parameter int LENGTH_BYTES = lptsc_pkg::LENGTH_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [lptsc_pkg::BYTE_W-1:0]    in_byte,
   input  logic                            chunk_start,
   output logic                            push,
   output lptsc_pkg::lptsc_cmd_type        push_cmd
);

   localparam logic [lptsc_pkg::LEN_CNT_W:0] LAST_CNT =
      (lptsc_pkg::LEN_CNT_W+1)'(LENGTH_BYTES - 1);

   logic                             in_payload_ff, in_payload_in;
   logic [lptsc_pkg::LEN_CNT_W-1:0]  len_cnt_ff, len_cnt_in;
   logic [lptsc_pkg::LEN_W-1:0]      len_acc_ff, len_acc_in;
   logic [lptsc_pkg::LEN_W-1:0]      remain_ff, remain_in;

   logic                             payload_base;
   logic [lptsc_pkg::LEN_CNT_W-1:0]  cnt_base;
   logic [lptsc_pkg::LEN_W-1:0]      acc_base;
   logic [lptsc_pkg::LEN_W-1:0]      remain_base;
   logic [lptsc_pkg::LEN_W-1:0]      acc_shift;
   logic [lptsc_pkg::LEN_W-1:0]      remain_dec;

   // Resync to the length phase on chunk start
   assign payload_base = chunk_start ? 1'b0 : in_payload_ff;
   assign cnt_base     = chunk_start ? '0 : len_cnt_ff;
   assign acc_base     = chunk_start ? '0 : len_acc_ff;
   assign remain_base  = chunk_start ? '0 : remain_ff;
   assign acc_shift    = {acc_base[lptsc_pkg::LEN_W-lptsc_pkg::BYTE_W-1:0], in_byte};
   assign remain_dec   = remain_base - lptsc_pkg::LEN_W'(1);

   // Classify the byte and work out the next parser state
   always_comb begin
      in_payload_in = in_payload_ff;
      len_cnt_in    = len_cnt_ff;
      len_acc_in    = len_acc_ff;
      remain_in     = remain_ff;
      push          = 1'b0;
      push_cmd.kind = lptsc_pkg::CMD_PAYLOAD;
      push_cmd.data = in_byte;
      if (accept) begin
         len_cnt_in    = cnt_base;
         len_acc_in    = acc_base;
         remain_in     = remain_base;
         in_payload_in = payload_base;
         if (payload_base) begin
            push          = 1'b1;
            remain_in     = remain_dec;
            in_payload_in = (remain_dec != '0);
         end else if ({1'b0, cnt_base} == LAST_CNT) begin
            push          = 1'b1;
            push_cmd.kind = lptsc_pkg::CMD_START;
            remain_in     = acc_shift;
            in_payload_in = (acc_shift != '0);
            len_cnt_in    = '0;
            len_acc_in    = '0;
         end else begin
            len_cnt_in = cnt_base + lptsc_pkg::LEN_CNT_W'(1);
            len_acc_in = acc_shift;
         end
      end
   end

   // Hold parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         len_cnt_ff    <= '0;
         len_acc_ff    <= '0;
         remain_ff     <= '0;
      end else begin
         in_payload_ff <= in_payload_in;
         len_cnt_ff    <= len_cnt_in;
         len_acc_ff    <= len_acc_in;
         remain_ff     <= remain_in;
      end
   end

endmodule

// File: rtl/lptsc_queue.sv
// Short command queue between the front parser and the back expander.
// Depends on lptsc_pkg.
module lptsc_queue #(
   parameter int QUEUE_DEPTH = lptsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lptsc_pkg::lptsc_cmd_type      push_cmd,
   input  logic                          pop,
   output lptsc_pkg::lptsc_cmd_type      head_cmd,
   output lptsc_pkg::lptsc_qstat_type    qstat
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   lptsc_pkg::lptsc_cmd_type  mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   assign qstat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign head_cmd    = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store commands
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/lptsc_back.sv
// Back expander: turns queue commands into output beats, four for a start
// code and one for a payload byte, through an output register. Depends on lptsc_pkg.
module lptsc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lptsc_pkg::lptsc_cmd_type      head_cmd,
   input  lptsc_pkg::lptsc_qstat_type    qstat,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [lptsc_pkg::BYTE_W-1:0]  out_byte,
   output logic                          out_begin,
   output logic                          out_last
);

   localparam logic [lptsc_pkg::SC_IDX_W-1:0] SC_LAST =
      lptsc_pkg::SC_IDX_W'(lptsc_pkg::SC_BYTES - 1);

   logic                               valid_ff, valid_in;
   logic [lptsc_pkg::SC_IDX_W-1:0]     sub_ff, sub_in;
   logic [lptsc_pkg::BYTE_W-1:0]       byte_ff, byte_in;
   logic                               begin_ff, begin_in;
   logic                               last_ff, last_in;
   logic                               load;
   logic                               is_start;

   assign load     = (!valid_ff || out_ready) && !qstat.empty;
   assign is_start = (head_cmd.kind == lptsc_pkg::CMD_START);
   assign pop      = load && (!is_start || (sub_ff == SC_LAST));

   // Build the next beat from the queue head
   always_comb begin
      valid_in = valid_ff;
      sub_in   = sub_ff;
      byte_in  = byte_ff;
      begin_in = begin_ff;
      last_in  = last_ff;
      if (valid_ff && out_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         if (is_start) begin
            byte_in  = lptsc_pkg::start_code_byte(sub_ff);
            begin_in = (sub_ff == '0);
            last_in  = (sub_ff == SC_LAST);
            sub_in   = (sub_ff == SC_LAST) ? '0 : sub_ff + lptsc_pkg::SC_IDX_W'(1);
         end else begin
            byte_in  = head_cmd.data;
            begin_in = 1'b0;
            last_in  = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      begin_ff <= begin_in;
      last_ff  <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_begin = begin_ff;
   assign out_last  = last_ff;

endmodule

// File: rtl/length_prefix_to_start_code.sv
// Top level of the length-prefix to start-code converter: front parser,
// command queue and back expander. Depends on lptsc_pkg and the lptsc_* modules.
//
// Converts a stream of NAL units, each led by a big-endian length of
// LENGTH_BYTES bytes, into a stream delimited by the start code 00 00 00 01.
// Length bytes give no output until the last one, which gives the four
// start-code beats (tuser high on the first, tlast on the fourth); payload
// bytes pass through one beat each with tlast high. A zero length gives only
// the start code. tuser high on an input beat resyncs the parser so that
// this byte is the first length byte, and any rest of the payload is
// dropped. The front takes one input beat per cycle while the command queue
// (QUEUE_DEPTH entries) has room; the back sends one output beat per cycle
// while the queue is not empty and the receiver is ready. For LENGTH_BYTES=4
// the sustained rate is one input beat per cycle while the receiver is
// ready; the output register and the queue let either side stall independently.
module length_prefix_to_start_code #(
   parameter int LENGTH_BYTES = lptsc_pkg::LENGTH_BYTES_DEF,
   parameter int QUEUE_DEPTH  = lptsc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] chunk_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tuser,   // [0] nal_begin
   output logic        rsp_tlast
);

   logic                          accept;
   logic                          push;
   logic                          pop;
   lptsc_pkg::lptsc_cmd_type      push_cmd;
   lptsc_pkg::lptsc_cmd_type      head_cmd;
   lptsc_pkg::lptsc_qstat_type    qstat;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   lptsc_front #(
      .LENGTH_BYTES(LENGTH_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_tdata),
      .chunk_start (req_tuser),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   lptsc_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .qstat    (qstat)
   );

   lptsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_cmd  (head_cmd),
      .qstat     (qstat),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (rsp_tdata),
      .out_begin (rsp_tuser),
      .out_last  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // The front never writes into a full queue
   assert property (@(posedge clock) disable iff (reset) push |-> !qstat.full)
      else $error("command queue overflow");

   // The first start-code beat is a zero byte and never ends the group
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 8'h00 && !rsp_tlast))
      else $error("bad first start-code beat");

   // The second start-code beat follows right after the first is taken
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tuser) |=>
      (rsp_tvalid && rsp_tdata == 8'h00 && !rsp_tuser && !rsp_tlast))
      else $error("start code broken after first beat");
`endif

endmodule

// File: tb/tb_length_prefix_to_start_code.sv
// Testbench for length_prefix_to_start_code: drives length-prefixed NAL units with
// random idling and back-pressure, predicts the start-code stream, checks every beat.
// Depends on lptsc_pkg and the length_prefix_to_start_code RTL.

// Converter model and store of expected output beats
class start_code_scoreboard;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       nal_begin;
      logic       last;
   } beat_type;

   // Parser state
   bit          in_payload;
   logic [1:0]  len_count;
   logic [31:0] len_acc;
   logic [31:0] remaining;

   beat_type expected_beats[$];
   int       failures;

   function new();
      in_payload = 1'b0;
      len_count  = '0;
      len_acc    = '0;
      remaining  = '0;
      failures   = 0;
   endfunction

   function int outstanding();
      return expected_beats.size();
   endfunction

   // Append one beat to the expected stream
   function void add_expected(beat_type nb);
      expected_beats = {expected_beats, nb};
   endfunction

   // Predict the beats caused by one accepted input beat
   function void note_byte(logic [7:0] b, logic resync);
      beat_type nb;
      int       k;
      if (resync) begin
         in_payload = 1'b0;
         len_count  = '0;
         len_acc    = '0;
         remaining  = '0;
      end
      if (in_payload) begin
         nb.out_byte  = b;
         nb.nal_begin = 1'b0;
         nb.last      = 1'b1;
         add_expected(nb);
         remaining = remaining - 32'd1;
         if (remaining == 0) in_payload = 1'b0;
         return;
      end
      len_acc = {len_acc[23:0], b};
      if (int'(len_count) + 1 < lptsc_pkg::LENGTH_BYTES_DEF) begin
         len_count = len_count + 2'd1;
         return;
      end
      // Emit the start code, most significant byte first
      for (k = 0; k < 4; k++) begin
         nb.out_byte  = lptsc_pkg::START_CODE_WORD[8*(3-k) +: 8];
         nb.nal_begin = (k == 0);
         nb.last      = (k == 3);
         add_expected(nb);
      end
      remaining  = len_acc;
      in_payload = (len_acc != 0);
      len_count  = '0;
      len_acc    = '0;
   endfunction

   // Compare one output beat with the oldest expectation
   function void check_beat(logic [7:0] d, logic u, logic l);
      beat_type want;
      if (expected_beats.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected beat: data %h begin %b last %b", d, u, l);
         return;
      end
      want = expected_beats.pop_front();
      if (want.out_byte !== d || want.nal_begin !== u || want.last !== l) begin
         failures++;
         if (failures <= 10)
            $display("mismatch: expected data %h begin %b last %b, got data %h begin %b last %b",
                     want.out_byte, want.nal_begin, want.last, d, u, l);
      end
   endfunction

endclass

module tb_length_prefix_to_start_code;

   localparam int ITEM_TARGET  = 280;
   localparam int IDLE_OFF_AT  = 245;
   localparam int HOLD_AT      = 60;
   localparam int DRAIN_AT     = 160;
   localparam int LONG_HOLD    = 40;
   localparam int STALL_LIMIT  = 1000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] in_byte
   logic        req_tuser = 1'b0; // [0] chunk_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [7:0] out_byte
   logic        rsp_tuser;        // [0] nal_begin
   logic        rsp_tlast;

   start_code_scoreboard sb = new();

   int items_sent    = 0;
   bit idle_on       = 1'b1;
   bit long_hold_req = 1'b0;
   int stall_count   = 0;

   length_prefix_to_start_code i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Note accepted input beats, then check accepted output beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

   // Receiver: random short stalls, one long hold on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end else if (stall == 0 && idle_on && $urandom_range(0, 6) == 0) begin
            stall = $urandom_range(1, 3);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run when no beat moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_count <= 0;
      else
         stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one input beat and hold it until accepted, then maybe idle
   task automatic send_byte(input logic [7:0] b, input logic cs);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= cs;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         req_tuser  <= 1'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Send a big-endian length header
   task automatic send_length(input logic [31:0] len, input logic cs);
      send_byte(len[31:24], cs);
      send_byte(len[23:16], 1'b0);
      send_byte(len[15:8], 1'b0);
      send_byte(len[7:0], 1'b0);
   endtask

   // Drop valid and wait until every predicted beat has arrived
   task automatic drain_outputs();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      logic [31:0] len;
      int          choice;
      bit          force_sync;
      bit          hold_done;
      bit          drain_done;
      force_sync = 1'b0;
      hold_done  = 1'b0;
      drain_done = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Zero length with resync on the very first byte: start code only
      send_length(32'h0, 1'b1);
      // Short unit with extreme payload values
      send_length(32'h2, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      // Largest length, cut short by a resync in mid payload
      send_length(32'hFFFF_FFFF, 1'b0);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_length(32'h1, 1'b1);
      send_byte(8'h7E, 1'b0);
      // Resync in mid length header
      send_byte(8'h00, 1'b0);
      send_length(32'h0, 1'b1);

      // Mostly well-formed units, some broken ones and noise
      while (items_sent < ITEM_TARGET) begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            long_hold_req = 1'b1;
         end
         if (!drain_done && items_sent >= DRAIN_AT) begin
            drain_done = 1'b1;
            drain_outputs();
         end
         if (items_sent >= IDLE_OFF_AT) idle_on = 1'b0;

         choice = $urandom_range(0, 9);
         if (choice < 8) begin
            if ($urandom_range(0, 9) == 0) len = $urandom_range(7, 24);
            else len = $urandom_range(0, 6);
            send_length(len, force_sync || ($urandom_range(0, 3) == 0));
            force_sync = 1'b0;
            repeat (len) send_byte(8'($urandom), 1'b0);
         end else if (choice == 8) begin
            // Huge length with truncated payload; the next unit resyncs
            len = ($urandom_range(0, 1) == 0) ? 32'h0100_0000 : 32'($urandom);
            send_length(len, force_sync || ($urandom_range(0, 1) == 0));
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
            force_sync = 1'b1;
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom));
            force_sync = 1'b1;
         end
      end

      drain_outputs();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/lptsc_pkg.sv
rtl/lptsc_front.sv
rtl/lptsc_queue.sv
rtl/lptsc_back.sv
rtl/length_prefix_to_start_code.sv
tb/tb_length_prefix_to_start_code.sv
